[hdl/mlpd_pkg.sv]
// ----------------------------------------------------------------------------
// mlpd_pkg
// Types, constants and helpers shared by the packet deframer modules.
// ----------------------------------------------------------------------------
package mlpd_pkg;

    // payload length field and register widths
    localparam int LENGTH_BITS = 20;
    localparam int CFG_BITS    = 20;
    localparam int HDR_BITS    = 32;

    // header window
    localparam int WINDOW_DEPTH = 8;
    localparam int FILL_BITS    = $clog2(WINDOW_DEPTH + 1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);

    // magic word "VID0"
    localparam logic [7:0] MAGIC_0 = 8'h56;
    localparam logic [7:0] MAGIC_1 = 8'h49;
    localparam logic [7:0] MAGIC_2 = 8'h44;
    localparam logic [7:0] MAGIC_3 = 8'h30;

    // rtp h.264 classification
    localparam int         TYPE_BITS     = 5;
    localparam int         POS_BITS      = 5;
    localparam logic [4:0] TYPE_SPS      = 5'd7;
    localparam logic [4:0] TYPE_PPS      = 5'd8;
    localparam logic [4:0] TYPE_STAP_A   = 5'd24;
    localparam logic [4:0] TYPE_BYTE_POS = 5'd12;
    localparam logic [4:0] STAP_BYTE_POS = 5'd15;
    localparam logic [4:0] POS_SATURATE  = 5'd16;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_MIN_LENGTH = 1'b0,
        REG_MAX_LENGTH = 1'b1
    } mlpd_reg_t;

    // front state
    typedef enum logic [0:0] {
        ST_HUNT    = 1'b0,
        ST_PAYLOAD = 1'b1
    } mlpd_state_t;

    // one payload item
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_of_packet;
        logic       last_of_packet;
        logic       keep_packet;
    } mlpd_item_t;

    // queue head as seen by the back part
    typedef struct packed {
        logic       valid;
        mlpd_item_t item;
    } mlpd_head_t;

    // sps or pps nal unit type
    function automatic logic is_param_set(input logic [TYPE_BITS-1:0] t);
        is_param_set = (t == TYPE_SPS) || (t == TYPE_PPS);
    endfunction

endpackage

[hdl/mlpd_front.sv]
// ----------------------------------------------------------------------------
// mlpd_front
// Hunts for the magic/length header, tracks payload and classifies packets.
// ----------------------------------------------------------------------------
module mlpd_front
    import mlpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                in_accept,
    input  logic [7:0]          in_byte,
    input  logic                in_flush,
    output logic                push,
    output mlpd_item_t          push_item
);

    logic [CFG_BITS-1:0]    min_len_reg;
    logic [CFG_BITS-1:0]    max_len_reg;
    logic [7:0]             win_reg  [WINDOW_DEPTH];
    logic [7:0]             win_next [WINDOW_DEPTH];
    logic [FILL_BITS-1:0]   fill_reg, fill_next;
    mlpd_state_t            state_reg, state_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [TYPE_BITS-1:0]   type_reg, type_next;
    logic                   pss_reg, pss_next;
    logic [HDR_BITS-1:0]    hdr_len;
    logic                   hdr_ok;
    logic                   last;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= CFG_BITS'(12);
            max_len_reg <= CFG_BITS'(65535);
        end
        else if (cfg_we)
        begin
            unique case (mlpd_reg_t'(cfg_addr))
                REG_MIN_LENGTH: min_len_reg <= cfg_wdata;
                REG_MAX_LENGTH: max_len_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // window shifted by the incoming byte, newest last
    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++)
        begin
            win_next[i] = win_reg[i+1];
        end
        win_next[WINDOW_DEPTH-1] = in_byte;
    end

    // header test on the shifted window
    assign hdr_len = {win_next[4], win_next[5], win_next[6], win_next[7]};
    assign hdr_ok  = (win_next[0] == MAGIC_0) && (win_next[1] == MAGIC_1)
                  && (win_next[2] == MAGIC_2) && (win_next[3] == MAGIC_3)
                  && (hdr_len >= HDR_BITS'(min_len_reg))
                  && (hdr_len <= HDR_BITS'(max_len_reg))
                  && ((hdr_len >> LENGTH_BITS) == '0);

    assign last = (left_reg == LENGTH_BITS'(1));

    // next state and item
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        type_next  = type_reg;
        pss_next   = pss_reg;
        push       = 1'b0;
        push_item.payload_byte    = in_byte;
        push_item.first_of_packet = (pos_reg == '0);
        push_item.last_of_packet  = last;
        push_item.keep_packet     = 1'b0;
        if (in_accept)
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    if (fill_reg != FILL_BITS'(WINDOW_DEPTH))
                        fill_next = fill_reg + FILL_BITS'(1);
                    if ((fill_next == FILL_BITS'(WINDOW_DEPTH)) && hdr_ok)
                    begin
                        fill_next = '0;
                        pos_next  = '0;
                        type_next = '0;
                        pss_next  = 1'b0;
                        if (hdr_len != '0)
                        begin
                            left_next  = hdr_len[LENGTH_BITS-1:0];
                            state_next = ST_PAYLOAD;
                        end
                    end
                end
                ST_PAYLOAD:
                begin
                    push = 1'b1;
                    // nal type capture and sps/pps test
                    if (pos_reg == TYPE_BYTE_POS)
                    begin
                        type_next = in_byte[TYPE_BITS-1:0];
                        if (is_param_set(in_byte[TYPE_BITS-1:0]))
                            pss_next = 1'b1;
                    end
                    else if (pos_reg == STAP_BYTE_POS)
                    begin
                        if ((type_reg == TYPE_STAP_A) && is_param_set(in_byte[TYPE_BITS-1:0]))
                            pss_next = 1'b1;
                    end
                    if (pos_reg < POS_SATURATE)
                        pos_next = pos_reg + POS_BITS'(1);
                    if (last)
                    begin
                        push_item.keep_packet = in_flush ? pss_next : 1'b1;
                        state_next = ST_HUNT;
                        left_next  = '0;
                        fill_next  = '0;
                    end
                    else
                    begin
                        left_next = left_reg - LENGTH_BITS'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            fill_reg  <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
            type_reg  <= '0;
            pss_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            type_reg  <= type_next;
            pss_reg   <= pss_next;
        end
    end

    // header window, only read once fully refilled
    always_ff @(posedge clk)
    begin
        if (in_accept && (state_reg == ST_HUNT))
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

[hdl/mlpd_queue.sv]
// ----------------------------------------------------------------------------
// mlpd_queue
// Short shifting queue of payload items between front and back.
// ----------------------------------------------------------------------------
module mlpd_queue
    import mlpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  mlpd_item_t push_item,
    input  logic       pop,
    output logic       full,
    output mlpd_head_t head
);

    mlpd_item_t           ent_reg [QUEUE_DEPTH];
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;
    logic [QCNT_BITS-1:0] wr_pos;

    assign full       = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.item  = ent_reg[0];

    // write slot accounts for a shift in the same cycle
    assign wr_pos = pop ? (cnt_reg - QCNT_BITS'(1)) : cnt_reg;

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_BITS'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // entries shift toward the head on pop, a new item lands in the write slot
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            if (push && (wr_pos[QIDX_BITS-1:0] == QIDX_BITS'(i)))
                ent_reg[i] <= push_item;
            else if (pop)
                ent_reg[i] <= ent_reg[i+1];
        end
        if (push && (wr_pos[QIDX_BITS-1:0] == QIDX_BITS'(QUEUE_DEPTH - 1)))
            ent_reg[QUEUE_DEPTH-1] <= push_item;
    end

endmodule

[hdl/mlpd_back.sv]
// ----------------------------------------------------------------------------
// mlpd_back
// Output register that drains the queue onto the master stream.
// ----------------------------------------------------------------------------
module mlpd_back
    import mlpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mlpd_head_t head,
    output logic       pop,
    input  logic       m_tready,
    output logic       m_tvalid,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [1:0] m_tuser
);

    logic       out_valid_reg, out_valid_next;
    mlpd_item_t out_item_reg;

    // load when the output register is empty or being taken
    assign pop = head.valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_item_reg <= head.item;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg.payload_byte;
    assign m_tlast  = out_item_reg.last_of_packet;
    assign m_tuser  = {out_item_reg.keep_packet, out_item_reg.first_of_packet};

endmodule

[hdl/magic_length_packet_deframer.sv]
// ----------------------------------------------------------------------------
// magic_length_packet_deframer
// Byte stream deframer locking on a "VID0" magic and 32-bit length header.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the received stream, one byte per item; s_tuser[0] selects
//   flush mode and is sampled on the item holding the final payload byte.
//   m_* carries payload bytes only; header and hunted bytes produce nothing.
//   m_tuser[0] marks the first byte, m_tlast the final one, and m_tuser[1]
//   on the final byte says whether the packet is kept (always in normal mode,
//   only sps/pps packets in flush mode).
//   cfg_we/cfg_addr/cfg_wdata write min_length (0) and max_length (1);
//   write only while no packet is in flight.
// Timing:
//   one item per clock sustained while m_tready stays high; a payload byte
//   accepted at the input is registered into the queue by the front, then
//   taken into the output register, which drives m_tvalid, and leaves it
//   once m_tready is high.
//   reset empties the queue and the header window and restores the default
//   length bounds 12..65535.
//   when m_tready is low the four-entry queue absorbs items; s_tready drops
//   only once it is full and returns as soon as one item leaves.
// ----------------------------------------------------------------------------
module magic_length_packet_deframer
    import mlpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tuser,   // [0] flush_active
    // output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] payload_byte
    output logic                m_tlast,
    output logic [1:0]          m_tuser    // [0] first_of_packet, [1] keep_packet
);

    logic       full;
    logic       push;
    logic       pop;
    mlpd_item_t push_item;
    mlpd_head_t head;

    assign s_tready = !full;

    // header hunt and classification
    mlpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_accept (s_tvalid && s_tready),
        .in_byte   (s_tdata),
        .in_flush  (s_tuser),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    mlpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .head      (head)
    );

    // output stage
    mlpd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[hdl/mlpd_checker.sv]
// ----------------------------------------------------------------------------
// mlpd_checker
// Port-level checks on the deframer output stream.
// ----------------------------------------------------------------------------
module mlpd_checker
    import mlpd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    logic in_pkt_reg;

    // tracks whether a packet is open on the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_pkt_reg <= 1'b0;
        else if (m_tvalid && m_tready)
            in_pkt_reg <= !m_tlast;
    end

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output item changed while stalled");

    // keep flag only on the final byte
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !m_tuser[1])
        else $error("keep set on a non-final byte");

    // a new packet starts with a first mark
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !in_pkt_reg |-> m_tuser[0])
        else $error("packet started without first mark");

    // no first mark inside a packet
    a_no_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && in_pkt_reg |-> !m_tuser[0])
        else $error("first mark inside an open packet");

endmodule

bind magic_length_packet_deframer mlpd_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

[sim/magic_length_packet_deframer_tb.sv]
// ----------------------------------------------------------------------------
// magic_length_packet_deframer_tb
// Self-checking regression for the magic/length byte stream deframer.
// A short table of hand-made bytes locks on one header and checks a packet.
// Random framed packets follow: noise, broken magic and out-of-bound lengths
// mixed in, across several length bounds and idling patterns. Every payload
// byte is compared against a cycle-free model of the hunting and flush logic.
// ----------------------------------------------------------------------------
module magic_length_packet_deframer_tb;
    import mlpd_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int PRESSURE_HOLD = 300;
    localparam int PHASE_ITEMS   = 230;
    localparam int NUM_PHASES    = 9;
    localparam int MAX_BODY      = 400;

    // one hand-written input item, with an optional typed result
    typedef struct packed {
        logic [7:0] data_byte;
        logic       flush;
        logic       typed;
        mlpd_item_t result;
    } stim_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_addr  = 1'b0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;   // [7:0] data_byte
    logic                s_tuser   = 1'b0; // [0] flush_active
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;          // [7:0] payload_byte
    logic                m_tlast;
    logic [1:0]          m_tuser;          // [0] first_of_packet, [1] keep_packet

    // deframer model state
    logic [7:0]          hunt_win [WINDOW_DEPTH];
    int unsigned         hunt_fill;
    bit                  in_pkt;
    logic [LENGTH_BITS-1:0] remaining;
    logic [POS_BITS-1:0] pay_pos;
    logic [TYPE_BITS-1:0] nal_type;
    bit                  ps_found;
    logic [CFG_BITS-1:0] min_len;
    logic [CFG_BITS-1:0] max_len;

    mlpd_item_t          expected_bytes [$];

    // run control and statistics
    int unsigned         idle_mode;
    bit                  pressure_armed;
    int unsigned         hold_count;
    int unsigned         stall_cycles;
    int unsigned         mismatches;
    int unsigned         items_sent;
    int unsigned         bytes_checked;
    int unsigned         packets_locked;
    int unsigned         packets_kept;
    int unsigned         packets_dropped;

    // length bounds per random phase: default, widest, zero only, one byte,
    // crossed, unreachable top, small window, narrow window, default again
    logic [CFG_BITS-1:0] phase_min [NUM_PHASES] =
        '{20'd12, 20'd0, 20'd0, 20'd1, 20'd20, 20'hFFFFF, 20'd0, 20'd13, 20'd12};
    logic [CFG_BITS-1:0] phase_max [NUM_PHASES] =
        '{20'd65535, 20'hFFFFF, 20'd0, 20'd1, 20'd10, 20'hFFFFF, 20'd40, 20'd16, 20'd65535};

    // garbage, a slide past a false start, a 13 byte sps packet ending in flush
    stim_row_t directed_rows [23] = '{
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{MAGIC_0, 1'b0, 1'b0, '0},
        '{MAGIC_1, 1'b0, 1'b0, '0},
        '{MAGIC_2, 1'b0, 1'b0, '0},
        '{MAGIC_3, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h0D, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h60, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'h03, 1'b0, 1'b0, '0},
        '{8'h04, 1'b0, 1'b0, '0},
        '{8'h05, 1'b0, 1'b0, '0},
        '{8'h06, 1'b0, 1'b0, '0},
        '{8'h07, 1'b0, 1'b0, '0},
        '{8'h08, 1'b0, 1'b0, '0},
        '{8'h67, 1'b1, 1'b1, '{8'h67, 1'b0, 1'b1, 1'b1}}
    };

    magic_length_packet_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hunt for a header or emit one payload byte
    task automatic deframe_step(input logic [7:0] b, input logic flush,
                                output bit produced, output mlpd_item_t item);
        logic [31:0] hdr_len;
        produced = 1'b0;
        item     = '0;
        if (!in_pkt)
        begin
            if (hunt_fill < WINDOW_DEPTH)
            begin
                hunt_win[hunt_fill] = b;
                hunt_fill++;
            end
            else
            begin
                for (int k = 0; k < WINDOW_DEPTH - 1; k++)
                    hunt_win[k] = hunt_win[k + 1];
                hunt_win[WINDOW_DEPTH - 1] = b;
            end
            hdr_len = {hunt_win[4], hunt_win[5], hunt_win[6], hunt_win[7]};
            if (hunt_fill == WINDOW_DEPTH && hunt_win[0] == MAGIC_0 &&
                hunt_win[1] == MAGIC_1 && hunt_win[2] == MAGIC_2 &&
                hunt_win[3] == MAGIC_3 && hdr_len >= min_len && hdr_len <= max_len &&
                (hdr_len >> LENGTH_BITS) == 0)
            begin
                hunt_fill = 0;
                pay_pos   = '0;
                nal_type  = '0;
                ps_found  = 1'b0;
                packets_locked++;
                // a zero length header locks and releases at once
                if (hdr_len != 0)
                begin
                    remaining = hdr_len[LENGTH_BITS-1:0];
                    in_pkt    = 1'b1;
                end
            end
        end
        else
        begin
            item.payload_byte    = b;
            item.first_of_packet = (pay_pos == 0);
            item.last_of_packet  = (remaining == 1);
            // nal type at byte 12, or stap-a inner type at byte 15
            if (pay_pos == TYPE_BYTE_POS)
            begin
                nal_type = b[TYPE_BITS-1:0];
                if (nal_type == TYPE_SPS || nal_type == TYPE_PPS)
                    ps_found = 1'b1;
            end
            else if (pay_pos == STAP_BYTE_POS && nal_type == TYPE_STAP_A &&
                     (b[TYPE_BITS-1:0] == TYPE_SPS || b[TYPE_BITS-1:0] == TYPE_PPS))
                ps_found = 1'b1;
            if (pay_pos < POS_SATURATE)
                pay_pos++;
            if (item.last_of_packet)
            begin
                item.keep_packet = flush ? ps_found : 1'b1;
                if (item.keep_packet)
                    packets_kept++;
                else
                    packets_dropped++;
                in_pkt    = 1'b0;
                remaining = '0;
                hunt_fill = 0;
            end
            else
                remaining--;
            produced = 1'b1;
        end
    endtask

    // offer one input item, wait for acceptance, then queue its payload byte
    task automatic push_byte(input logic [7:0] b, input logic flush,
                             input bit use_typed, input mlpd_item_t typed);
        bit         produced;
        mlpd_item_t predicted;
        while ((idle_mode == 1 && $urandom_range(99) < 73) ||
               (idle_mode == 3 && $urandom_range(99) < 24))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= flush;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        deframe_step(b, flush, produced, predicted);
        if (use_typed)
            expected_bytes = {expected_bytes, typed};
        else if (produced)
            expected_bytes = {expected_bytes, predicted};
    endtask

    // one framed packet with noise ahead, sometimes broken or out of bounds
    task automatic send_packet();
        int unsigned noise;
        int unsigned pick;
        int unsigned span;
        int unsigned body;
        int unsigned sel;
        bit          shaped;
        logic [31:0] hdr_len;
        logic [7:0]  hdr [WINDOW_DEPTH];
        logic [7:0]  b;
        noise = $urandom_range(3);
        repeat (noise)
            push_byte(($urandom_range(7) == 0) ? MAGIC_0 : 8'($urandom),
                      1'($urandom_range(1)), 1'b0, '0);
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            if (min_len > max_len || min_len > MAX_BODY)
                hdr_len = $urandom_range(60);
            else
            begin
                span    = (pick < 5) ? 300 : 40;
                hdr_len = (max_len - min_len > span) ?
                          $urandom_range(min_len + span, min_len) :
                          $urandom_range(max_len, min_len);
            end
        end
        else if (pick < 80)
            hdr_len = 0;
        else if (pick < 90)
            hdr_len = $urandom_range(1) ? 32'(max_len) + 1 + $urandom_range(20)
                                        : 32'(min_len) - 1 - $urandom_range(20);
        else
            hdr_len = $urandom | 32'h8000_0000;
        hdr = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3,
                hdr_len[31:24], hdr_len[23:16], hdr_len[15:8], hdr_len[7:0]};
        // occasional single bit error in the magic
        if ($urandom_range(9) == 0)
        begin
            sel      = $urandom_range(3);
            hdr[sel] = hdr[sel] ^ 8'(1 << $urandom_range(7));
        end
        for (int k = 0; k < WINDOW_DEPTH; k++)
            push_byte(hdr[k], 1'($urandom_range(1)), 1'b0, '0);
        body   = (hdr_len <= MAX_BODY) ? hdr_len : $urandom_range(20);
        shaped = ($urandom_range(9) < 6);
        for (int k = 0; k < body; k++)
        begin
            b = $urandom;
            if (shaped && k == TYPE_BYTE_POS)
            begin
                sel = $urandom_range(3);
                b[4:0] = (sel == 0) ? TYPE_SPS : (sel == 1) ? TYPE_PPS :
                         (sel == 2) ? TYPE_STAP_A : b[4:0];
            end
            else if (shaped && k == STAP_BYTE_POS)
            begin
                sel = $urandom_range(2);
                b[4:0] = (sel == 0) ? TYPE_SPS : (sel == 1) ? TYPE_PPS : b[4:0];
            end
            push_byte(b, 1'($urandom_range(1)), 1'b0, '0);
        end
    endtask

    // finish any open packet and let the block drain
    task automatic settle();
        while (in_pkt)
            push_byte(8'h00, 1'($urandom_range(1)), 1'b0, '0);
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write both length bounds while the block is idle
    task automatic set_bounds(input logic [CFG_BITS-1:0] lo, input logic [CFG_BITS-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MIN_LENGTH;
        cfg_wdata <= lo;
        @(posedge clk);
        min_len   = lo;
        cfg_addr  <= REG_MAX_LENGTH;
        cfg_wdata <= hi;
        @(posedge clk);
        max_len   = hi;
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random stalls in idling patterns 2 and 3, plus one long hold-off
    always @(posedge clk)
    begin
        if (pressure_armed && hold_count < PRESSURE_HOLD)
        begin
            m_tready <= 1'b0;
            hold_count++;
        end
        else if (idle_mode == 2)
            m_tready <= ($urandom_range(99) >= 73);
        else if (idle_mode == 3)
            m_tready <= ($urandom_range(99) >= 24);
        else
            m_tready <= 1'b1;
    end

    // output check against the oldest expected payload byte
    always @(posedge clk)
    begin : check_output
        mlpd_item_t exp_item;
        mlpd_item_t got_item;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_item = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected output item: byte %h first %b last %b keep %b",
                         $time, got_item.payload_byte, got_item.first_of_packet,
                         got_item.last_of_packet, got_item.keep_packet);
                mismatches++;
            end
            else
            begin
                exp_item = expected_bytes.pop_front();
                bytes_checked++;
                if (got_item !== exp_item)
                begin
                    $display("%0t: mismatch: expected byte %h first %b last %b keep %b, got byte %h first %b last %b keep %b",
                             $time, exp_item.payload_byte, exp_item.first_of_packet,
                             exp_item.last_of_packet, exp_item.keep_packet,
                             got_item.payload_byte, got_item.first_of_packet,
                             got_item.last_of_packet, got_item.keep_packet);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item accepted for %0d cycles, %0d payload bytes outstanding",
                     $time, stall_cycles, expected_bytes.size());
            $display("magic_length_packet_deframer regression: fail");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        idle_mode       = 0;
        pressure_armed  = 1'b0;
        hold_count      = 0;
        stall_cycles    = 0;
        mismatches      = 0;
        items_sent      = 0;
        bytes_checked   = 0;
        packets_locked  = 0;
        packets_kept    = 0;
        packets_dropped = 0;
        for (int k = 0; k < WINDOW_DEPTH; k++)
            hunt_win[k] = '0;
        hunt_fill = 0;
        in_pkt    = 1'b0;
        remaining = '0;
        pay_pos   = '0;
        nal_type  = '0;
        ps_found  = 1'b0;
        min_len   = 20'd12;
        max_len   = 20'd65535;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset bounds
        foreach (directed_rows[r])
            push_byte(directed_rows[r].data_byte, directed_rows[r].flush,
                      directed_rows[r].typed, directed_rows[r].result);
        settle();

        // random phases, each with its own bounds and idling pattern
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            int unsigned phase_start;
            set_bounds(phase_min[p], phase_max[p]);
            idle_mode = p % 4;
            if (p == 0)
                pressure_armed = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_packet();
            settle();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d input items over %0d length settings and 4 idling patterns",
                 items_sent, NUM_PHASES + 1);
        $display("%0d headers locked, %0d payload bytes checked, %0d packets kept, %0d discarded",
                 packets_locked, bytes_checked, packets_kept, packets_dropped);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("magic_length_packet_deframer regression: pass");
        else
            $display("magic_length_packet_deframer regression: fail");
        $finish;
    end

endmodule

[filelist.f]
hdl/mlpd_pkg.sv
hdl/mlpd_front.sv
hdl/mlpd_queue.sv
hdl/mlpd_back.sv
hdl/magic_length_packet_deframer.sv
hdl/mlpd_checker.sv
sim/magic_length_packet_deframer_tb.sv
